FILE: rtl/core/sdm_pkg.sv
package sdm_pkg;

	localparam int MAX_DIGITS  = 64;
	localparam int PROD_DIGITS = 2 * MAX_DIGITS;
	localparam int DIG_W       = 4;
	localparam int OIDX_W      = $clog2(MAX_DIGITS);
	localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int PIDX_W      = $clog2(PROD_DIGITS);
	localparam int LEN_W       = $clog2(PROD_DIGITS + 1);
	localparam int RLEN_W      = 8;
	localparam int IDX_W       = 7;

	typedef enum logic [1:0] {
		KIND_LOAD_A,
		KIND_LOAD_B,
		KIND_COMPUTE,
		KIND_READ
	} kind_t;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	typedef enum logic [1:0] {
		DU_ADD,
		DU_SUB,
		DU_MAC
	} du_mode_t;

	typedef struct packed {
		logic [DIG_W-1:0] d;
		logic [DIG_W-1:0] c;
	} du_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_AS_RD,
		S_AS_EX,
		S_AS_TOP,
		S_M_RD,
		S_M_EX,
		S_M_CW,
		S_SC_RD,
		S_SC_EX,
		S_FIN
	} state_t;

	function automatic logic [RLEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
		if (LEN_W > RLEN_W && 32'(v) > 32'd255) begin
			return 8'd255;
		end
		return RLEN_W'(v);
	endfunction

endpackage

FILE: rtl/core/signed_decimal_add_sub_mul.sv
// signed decimal add / subtract / multiply unit, digit serial
// one command channel: a transaction is taken when start is high and busy is low
// kind selects load of a first or second operand digit (most significant first,
// first clears the operand and takes its sign), compute, or read of one result digit
// every transaction returns one result with a one-cycle done strobe; the receiver
// cannot stall, so the result must be taken in that cycle
// load: done one cycle after the transaction, no busy cycles
// read: busy for one cycle (registered product ram read), done two cycles after
// add: about 2*MAX_DIGITS+3 cycles, one digit every two cycles through the digit unit
// subtract: up to 4*MAX_DIGITS+2 cycles, a second pass runs with operands swapped
// when the first pass ends in a borrow
// multiply: 2*MAX_DIGITS^2 + MAX_DIGITS cycles of digit multiply-accumulate over the
// product ram plus a length scan of up to 4*MAX_DIGITS cycles; the ram
// read-modify-write loop sets this figure
// reset clears counts, signs, overflow and sets the result to zero of length one;
// operand and product rams are not cleared
module signed_decimal_add_sub_mul import sdm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [DIG_W-1:0]    digit,
	input  logic                first,
	input  logic                negative,
	input  logic [1:0]          operation,
	input  logic [IDX_W-1:0]    index,
	output logic                done,
	output logic [DIG_W-1:0]    result_digit,
	output logic                result_negative,
	output logic [RLEN_W-1:0]   result_length,
	output logic                overflow
);

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    cnt_a_q, cnt_b_q;
	logic                sgn_a_q, sgn_b_q, ovf_q;
	logic [LEN_W-1:0]    plen_q, wlen_q;
	logic                psgn_q, wsgn_q, wnz_q, sb_q;
	logic                done_q;
	logic [DIG_W-1:0]    rdig_q, carry_q;
	logic                sub_q, swap_q, va_q, vb_q, pz_q;
	logic [OIDX_W-1:0]   pos_q, row_q;
	logic [PIDX_W-1:0]   scan_q;
	logic [IDX_W-1:0]    ridx_q;

	logic                accept;
	logic [CNT_W-1:0]    eff_cnt_a, eff_cnt_b;
	logic [DIG_W-1:0]    ld_digit;
	logic                we_a, we_b, we_p;
	logic [OIDX_W-1:0]   raddr_a, raddr_b, lb;
	logic [PIDX_W-1:0]   raddr_p, waddr_p;
	logic [DIG_W-1:0]    wdata_p, rda, rdb, rdp;
	logic [DIG_W-1:0]    opx, opy, du_x, du_y, du_p;
	du_mode_t            du_mode;
	du_res_t             du_res;
	logic                va_d, vb_d, sb_d;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	assign eff_cnt_a = first ? '0 : cnt_a_q;
	assign eff_cnt_b = first ? '0 : cnt_b_q;
	assign ld_digit  = (digit > DIG_W'(9)) ? DIG_W'(9) : digit;

	assign we_a = accept && kind == KIND_LOAD_A && eff_cnt_a < CNT_W'(MAX_DIGITS);
	assign we_b = accept && kind == KIND_LOAD_B && eff_cnt_b < CNT_W'(MAX_DIGITS);

	assign lb      = (state_q == S_M_RD) ? row_q : pos_q;
	assign raddr_a = OIDX_W'(cnt_a_q - CNT_W'(1) - CNT_W'(pos_q));
	assign raddr_b = OIDX_W'(cnt_b_q - CNT_W'(1) - CNT_W'(lb));
	assign va_d    = CNT_W'(pos_q) < cnt_a_q;
	assign vb_d    = CNT_W'(lb) < cnt_b_q;
	assign sb_d    = sgn_b_q ^ (operation == OP_SUB);

	sdm_ram #(.WIDTH(DIG_W), .DEPTH(MAX_DIGITS)) u_ram_a (
		.clk(clk), .we(we_a), .waddr(eff_cnt_a[OIDX_W-1:0]), .wdata(ld_digit),
		.raddr(raddr_a), .rdata(rda)
	);

	sdm_ram #(.WIDTH(DIG_W), .DEPTH(MAX_DIGITS)) u_ram_b (
		.clk(clk), .we(we_b), .waddr(eff_cnt_b[OIDX_W-1:0]), .wdata(ld_digit),
		.raddr(raddr_b), .rdata(rdb)
	);

	sdm_ram #(.WIDTH(DIG_W), .DEPTH(PROD_DIGITS)) u_ram_p (
		.clk(clk), .we(we_p), .waddr(waddr_p), .wdata(wdata_p),
		.raddr(raddr_p), .rdata(rdp)
	);

	assign opx  = va_q ? rda : '0;
	assign opy  = vb_q ? rdb : '0;
	assign du_x = swap_q ? opy : opx;
	assign du_y = swap_q ? opx : opy;
	assign du_p = pz_q ? '0 : rdp;

	sdm_digit_unit u_du (
		.mode(du_mode), .x(du_x), .y(du_y), .p(du_p), .c(carry_q), .res(du_res)
	);

	always_comb begin
		state_d = state_q;
		we_p    = 1'b0;
		waddr_p = PIDX_W'(pos_q);
		wdata_p = du_res.d;
		raddr_p = scan_q;
		du_mode = sub_q ? DU_SUB : DU_ADD;
		case (state_q)
			S_IDLE: begin
				raddr_p = PIDX_W'(index);
				if (accept && kind == KIND_READ) begin
					state_d = S_READ;
				end else if (accept && kind == KIND_COMPUTE) begin
					if (operation == OP_ADD || operation == OP_SUB) begin
						state_d = S_AS_RD;
					end else if (operation == OP_MUL) begin
						state_d = S_M_RD;
					end
				end
			end
			S_READ: state_d = S_IDLE;
			S_AS_RD: state_d = S_AS_EX;
			S_AS_EX: begin
				we_p = 1'b1;
				if (pos_q == OIDX_W'(MAX_DIGITS - 1)) begin
					if (!sub_q) begin
						state_d = S_AS_TOP;
					end else if (du_res.c != '0 && !swap_q) begin
						state_d = S_AS_RD;
					end else begin
						state_d = S_FIN;
					end
				end else begin
					state_d = S_AS_RD;
				end
			end
			S_AS_TOP: begin
				we_p    = 1'b1;
				waddr_p = PIDX_W'(MAX_DIGITS);
				wdata_p = carry_q;
				state_d = S_FIN;
			end
			S_M_RD: begin
				raddr_p = PIDX_W'(row_q) + PIDX_W'(pos_q);
				state_d = S_M_EX;
			end
			S_M_EX: begin
				du_mode = DU_MAC;
				we_p    = 1'b1;
				waddr_p = PIDX_W'(row_q) + PIDX_W'(pos_q);
				state_d = (pos_q == OIDX_W'(MAX_DIGITS - 1)) ? S_M_CW : S_M_RD;
			end
			S_M_CW: begin
				we_p    = 1'b1;
				waddr_p = PIDX_W'(row_q) + PIDX_W'(MAX_DIGITS);
				wdata_p = carry_q;
				state_d = (row_q == OIDX_W'(MAX_DIGITS - 1)) ? S_SC_RD : S_M_RD;
			end
			S_SC_RD: state_d = S_SC_EX;
			S_SC_EX: begin
				if (rdp != '0 || scan_q == '0) begin
					state_d = S_FIN;
				end else begin
					state_d = S_SC_RD;
				end
			end
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			sgn_a_q <= 1'b0;
			sgn_b_q <= 1'b0;
			ovf_q   <= 1'b0;
			plen_q  <= LEN_W'(1);
			psgn_q  <= 1'b0;
			done_q  <= 1'b0;
			rdig_q  <= '0;
			sub_q   <= 1'b0;
			swap_q  <= 1'b0;
			sb_q    <= 1'b0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
			pz_q    <= 1'b0;
			pos_q   <= '0;
			row_q   <= '0;
			scan_q  <= '0;
			carry_q <= '0;
			wlen_q  <= LEN_W'(1);
			wnz_q   <= 1'b0;
			wsgn_q  <= 1'b0;
			ridx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			va_q   <= va_d;
			vb_q   <= vb_d;
			pz_q   <= row_q == '0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rdig_q <= '0;
						ridx_q <= index;
						case (kind)
							KIND_LOAD_A: begin
								done_q <= 1'b1;
								if (first) begin
									sgn_a_q <= negative;
								end
								if (eff_cnt_a < CNT_W'(MAX_DIGITS)) begin
									cnt_a_q <= eff_cnt_a + CNT_W'(1);
								end else begin
									cnt_a_q <= eff_cnt_a;
									ovf_q   <= 1'b1;
								end
							end
							KIND_LOAD_B: begin
								done_q <= 1'b1;
								if (first) begin
									sgn_b_q <= negative;
								end
								if (eff_cnt_b < CNT_W'(MAX_DIGITS)) begin
									cnt_b_q <= eff_cnt_b + CNT_W'(1);
								end else begin
									cnt_b_q <= eff_cnt_b;
									ovf_q   <= 1'b1;
								end
							end
							KIND_COMPUTE: begin
								pos_q   <= '0;
								row_q   <= '0;
								carry_q <= '0;
								swap_q  <= 1'b0;
								wlen_q  <= LEN_W'(1);
								wnz_q   <= 1'b0;
								sb_q    <= sb_d;
								sub_q   <= sgn_a_q != sb_d;
								if (operation == OP_MUL) begin
									wsgn_q <= sgn_a_q ^ sgn_b_q;
								end else begin
									wsgn_q <= sgn_a_q;
								end
								if (operation != OP_ADD && operation != OP_SUB &&
									operation != OP_MUL) begin
									done_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					done_q <= 1'b1;
					rdig_q <= (32'(ridx_q) < 32'(plen_q)) ? rdp : '0;
				end
				S_AS_EX: begin
					if (pos_q == OIDX_W'(MAX_DIGITS - 1) && sub_q && du_res.c != '0 &&
						!swap_q) begin
						swap_q  <= 1'b1;
						pos_q   <= '0;
						carry_q <= '0;
						wlen_q  <= LEN_W'(1);
						wnz_q   <= 1'b0;
						wsgn_q  <= sb_q;
					end else begin
						carry_q <= du_res.c;
						if (du_res.d != '0) begin
							wlen_q <= LEN_W'(pos_q) + LEN_W'(1);
							wnz_q  <= 1'b1;
						end
						if (pos_q != OIDX_W'(MAX_DIGITS - 1)) begin
							pos_q <= pos_q + OIDX_W'(1);
						end
					end
				end
				S_AS_TOP: begin
					if (carry_q != '0) begin
						wlen_q <= LEN_W'(MAX_DIGITS) + LEN_W'(1);
						wnz_q  <= 1'b1;
					end
				end
				S_M_EX: begin
					carry_q <= du_res.c;
					if (pos_q != OIDX_W'(MAX_DIGITS - 1)) begin
						pos_q <= pos_q + OIDX_W'(1);
					end
				end
				S_M_CW: begin
					carry_q <= '0;
					pos_q   <= '0;
					if (row_q == OIDX_W'(MAX_DIGITS - 1)) begin
						scan_q <= PIDX_W'(PROD_DIGITS - 1);
					end else begin
						row_q <= row_q + OIDX_W'(1);
					end
				end
				S_SC_EX: begin
					if (rdp != '0) begin
						wlen_q <= LEN_W'(scan_q) + LEN_W'(1);
						wnz_q  <= 1'b1;
					end else if (scan_q == '0) begin
						wlen_q <= LEN_W'(1);
						wnz_q  <= 1'b0;
					end else begin
						scan_q <= scan_q - PIDX_W'(1);
					end
				end
				S_FIN: begin
					plen_q <= wlen_q;
					psgn_q <= wnz_q & wsgn_q;
					done_q <= 1'b1;
					rdig_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign done            = done_q;
	assign result_digit    = rdig_q;
	assign result_negative = psgn_q;
	assign result_length   = sat_len(plen_q);
	assign overflow        = ovf_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result_length != '0)
		else $error("zero result length");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(overflow) |-> overflow)
		else $error("overflow flag cleared");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (kind == KIND_LOAD_A || kind == KIND_LOAD_B)) |=> done)
		else $error("load transaction without result");

endmodule

FILE: rtl/core/sdm_ram.sv
module sdm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/sdm_digit_unit.sv
module sdm_digit_unit import sdm_pkg::*; (
	input  du_mode_t         mode,
	input  logic [DIG_W-1:0] x,
	input  logic [DIG_W-1:0] y,
	input  logic [DIG_W-1:0] p,
	input  logic [DIG_W-1:0] c,
	output du_res_t          res
);

	logic [6:0]  t;
	logic [7:0]  prod;
	logic [14:0] recip;
	logic [6:0]  q;
	logic [5:0]  s;
	logic [5:0]  a_sum;

	always_comb begin
		prod  = 8'(x) * 8'(y);
		t     = 7'(p) + 7'(prod) + 7'(c);
		recip = 15'(t) * 15'd205;
		q     = 7'(recip >> 11);
		s     = 6'(x) - 6'(c) - 6'(y);
		a_sum = 6'(x) + 6'(y) + 6'(c);
		res   = '0;
		case (mode)
			DU_ADD: begin
				if (a_sum > 6'd9) begin
					res.d = DIG_W'(a_sum - 6'd10);
					res.c = DIG_W'(1);
				end else begin
					res.d = DIG_W'(a_sum);
				end
			end
			DU_SUB: begin
				if (s[5]) begin
					res.d = DIG_W'(s + 6'd10);
					res.c = DIG_W'(1);
				end else begin
					res.d = DIG_W'(s);
				end
			end
			DU_MAC: begin
				res.d = DIG_W'(t - 7'(q * 7'd10));
				res.c = DIG_W'(q);
			end
			default: res = '0;
		endcase
	end

endmodule
